### rtl/core/aoit_pkg.sv
// Package with types and constants shared by the area-of-interest tracker.
package tracker_pkg;

    localparam logic [31:0] RESERVED_ID = 32'hFFFF_FFFF;
    localparam logic [30:0] HALF_RESET  = 31'd655360;

    // Item kinds.
    localparam logic [2:0] KIND_ENTER = 3'd0;
    localparam logic [2:0] KIND_LEAVE = 3'd1;
    localparam logic [2:0] KIND_MOVE  = 3'd2;
    localparam logic [2:0] KIND_MODE  = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;

    // Result kinds.
    localparam logic [1:0] EV_ENTER = 2'd0;
    localparam logic [1:0] EV_LEAVE = 2'd1;
    localparam logic [1:0] EV_VIEW  = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    // Done status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOCHG  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_X = 2'd0;
    localparam logic [1:0] CFG_HALF_Y = 2'd1;
    localparam logic [1:0] CFG_HALF_Z = 2'd2;

    // One stored object: id, position and mode flags.
    typedef struct packed {
        logic [31:0]        ident;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               watch;
        logic               mark;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        object_id;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               watch_flag;
        logic               mark_flag;
        logic               own_range;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] watcher_id;
        logic [31:0] target_id;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND,
        S_SCAN_RD,
        S_SCAN,
        S_EMIT,
        S_WRITE,
        S_DONE
    } state_t;

    // True when every axis differs by at most its half-width.
    function automatic logic in_view(input logic signed [31:0] ax, input logic signed [31:0] ay,
                                     input logic signed [31:0] az, input logic signed [31:0] bx,
                                     input logic signed [31:0] by, input logic signed [31:0] bz,
                                     input logic signed [32:0] hx, input logic signed [32:0] hy,
                                     input logic signed [32:0] hz);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [33:0] adx;
        logic signed [33:0] ady;
        logic signed [33:0] adz;
        dx  = 33'(ax) - 33'(bx);
        dy  = 33'(ay) - 33'(by);
        dz  = 33'(az) - 33'(bz);
        adx = dx[32] ? -34'(dx) : 34'(dx);
        ady = dy[32] ? -34'(dy) : 34'(dy);
        adz = dz[32] ? -34'(dz) : 34'(dz);
        return (adx <= 34'(hx)) && (ady <= 34'(hy)) && (adz <= 34'(hz));
    endfunction

endpackage

### rtl/core/aoit_ram.sv
// Generic single-port RAM with registered read.
module tracker_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the addressed entry into the output register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/area_of_interest_tracker.sv
// Top level of the area-of-interest tracker: sequencer around one slot memory.
// Every item starts with a lookup pass over all slots and ends with a done result. Leave, query,
// new enter and rising watch add one view pass; move and re-enter add two passes. Each member
// in view is walked as two pair halves for enter, leave and move, as one for query and watch.
// One item at a time; output stalls hold the sequencer. Reset clears slot-used flags and sets
// the view half-widths to HALF_RESET.
module area_of_interest_tracker
    import tracker_pkg::*;
#(
    parameter int MAX_OBJECTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    state_t state_reg, state_next;

    logic [30:0] half_x_reg, half_y_reg, half_z_reg;
    in_item_t    item_reg;
    logic [MAX_OBJECTS-1:0] used_reg, used_next;
    logic [MAX_OBJECTS-1:0] before_reg, before_next;
    logic [MAX_OBJECTS-1:0] mask_reg, mask_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] self_reg, self_next;
    logic          found_reg, found_next;
    slot_t         self_data_reg, self_data_next;
    // pass: 0 = old view of move or re-enter, 1 = final view
    logic          pass_reg, pass_next;
    logic          phase_reg, phase_next;   // move: 0 enters, 1 leaves
    logic          sub_reg, sub_next;       // pair half: 0 self watches, 1 other watches
    logic [1:0]    status_reg, status_next;

    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    slot_t         ram_wdata;
    slot_t         ram_rdata;

    logic [MAX_OBJECTS-1:0]  watch_bits_reg, watch_bits_next;
    logic [31:0]             ids_reg [MAX_OBJECTS];
    logic                    ids_we;

    state_t        decide_state;
    state_t        emit_state;
    logic          found_now;
    logic [AW-1:0] self_now;
    slot_t         self_now_data;
    logic          member_done;

    tracker_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_OBJECTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic last_idx;
    assign last_idx = (idx_reg == AW'(MAX_OBJECTS - 1));

    // Half-widths used for the current view test.
    logic signed [32:0] hx, hy, hz;
    always_comb
    begin
        if (item_reg.kind == KIND_QUERY && item_reg.own_range)
        begin
            hx = 33'(item_reg.coord_x);
            hy = 33'(item_reg.coord_y);
            hz = 33'(item_reg.coord_z);
        end
        else
        begin
            hx = {2'b00, half_x_reg};
            hy = {2'b00, half_y_reg};
            hz = {2'b00, half_z_reg};
        end
    end

    logic hit;
    assign hit = in_view(ram_rdata.x, ram_rdata.y, ram_rdata.z, self_data_reg.x,
                         self_data_reg.y, self_data_reg.z, hx, hy, hz);

    // Lowest free slot.
    logic          free_any;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_OBJECTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // Emit mask for the current pass and lowest pending member.
    logic [MAX_OBJECTS-1:0] emit_mask;
    logic                   emit_any;
    logic [AW-1:0]          emit_idx;
    always_comb
    begin
        if (item_reg.kind == KIND_MOVE)
            emit_mask = phase_reg ? (before_reg & ~mask_reg) : (mask_reg & ~before_reg);
        else
            emit_mask = mask_reg;
        emit_any = 1'b0;
        emit_idx = '0;
        for (int i = MAX_OBJECTS - 1; i >= 0; i--)
        begin
            if (emit_mask[i])
            begin
                emit_any = 1'b1;
                emit_idx = AW'(i);
            end
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // The watch flag of a member is kept in a register written during the scan.
    logic other_watch;
    assign other_watch = watch_bits_reg[emit_idx];

    // Event kind for pair events of the current item.
    logic [1:0] pair_kind;
    always_comb
    begin
        case (item_reg.kind)
            KIND_ENTER: pair_kind = (pass_reg) ? EV_ENTER : EV_LEAVE;
            KIND_LEAVE: pair_kind = EV_LEAVE;
            KIND_MOVE:  pair_kind = phase_reg ? EV_LEAVE : EV_ENTER;
            KIND_MODE:  pair_kind = EV_ENTER;
            default:    pair_kind = EV_VIEW;
        endcase
    end

    // Decisions made after the lookup pass and after each emit phase.
    always_comb
    begin
        found_now     = found_reg;
        self_now      = self_reg;
        self_now_data = self_data_reg;
        if (used_reg[idx_reg] && ram_rdata.ident == item_reg.object_id && !found_reg)
        begin
            found_now     = 1'b1;
            self_now      = idx_reg;
            self_now_data = ram_rdata;
        end
        decide_state = S_DONE;
        case (item_reg.kind) inside
            KIND_ENTER:
                if (item_reg.object_id == RESERVED_ID)
                    decide_state = S_DONE;
                else if (found_now)
                    decide_state = S_SCAN_RD;
                else if (free_any)
                    decide_state = S_WRITE;
                else
                    decide_state = S_DONE;
            KIND_LEAVE, KIND_QUERY:
                decide_state = found_now ? S_SCAN_RD : S_DONE;
            default:
                decide_state = S_DONE;
        endcase
        if (found_now && item_reg.kind == KIND_MOVE)
            decide_state = (self_now_data.x == item_reg.coord_x &&
                            self_now_data.y == item_reg.coord_y &&
                            self_now_data.z == item_reg.coord_z) ? S_DONE : S_SCAN_RD;
        if (found_now && item_reg.kind == KIND_MODE)
            decide_state = (!self_now_data.watch && item_reg.watch_flag) ? S_WRITE : S_DONE;

        // After the old object leaves, its slot is free in any case.
        emit_state = S_EMIT;
        if (!emit_any)
        begin
            emit_state = S_DONE;
            if (item_reg.kind == KIND_ENTER && !pass_reg)
                emit_state = S_WRITE;
            if (item_reg.kind == KIND_MOVE && !pass_reg)
                emit_state = S_WRITE;
            if (item_reg.kind == KIND_MOVE && pass_reg && !phase_reg)
                emit_state = S_EMIT;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_FIND_RD;
            S_FIND_RD:
                state_next = S_FIND;
            S_FIND:
                if (last_idx)
                    state_next = decide_state;
                else
                    state_next = S_FIND_RD;
            S_SCAN_RD:
                state_next = S_SCAN;
            S_SCAN:
                if (last_idx)
                    state_next = S_EMIT;
                else
                    state_next = S_SCAN_RD;
            S_EMIT:
                state_next = emit_state;
            S_WRITE:
                state_next = S_SCAN_RD;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Captured ids of scanned members, one register per slot.
    always_ff @(posedge clk)
    begin
        if (ids_we)
        begin
            ids_reg[idx_reg] <= ram_rdata.ident;
        end
    end

    // Sequencer data path.
    always_comb
    begin
        used_next       = used_reg;
        before_next     = before_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        self_next       = self_reg;
        found_next      = found_reg;
        self_data_next  = self_data_reg;
        pass_next       = pass_reg;
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        status_next     = status_reg;
        watch_bits_next = watch_bits_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = self_data_reg;
        ids_we          = 1'b0;
        member_done     = 1'b0;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next    = '0;
                found_next  = 1'b0;
                pass_next   = 1'b1;
                phase_next  = 1'b0;
                sub_next    = 1'b0;
                status_next = ST_OK;
                mask_next   = '0;
                before_next = '0;
            end
            S_FIND_RD:
            begin
                ram_addr = idx_reg;
            end
            S_FIND:
            begin
                found_next     = found_now;
                self_next      = self_now;
                self_data_next = self_now_data;
                idx_next       = last_idx ? '0 : idx_reg + AW'(1);
                if (last_idx)
                begin
                    mask_next = '0;
                    case (item_reg.kind) inside
                        KIND_ENTER:
                        begin
                            if (item_reg.object_id == RESERVED_ID)
                                status_next = ST_NOCHG;
                            else if (found_now)
                                pass_next = 1'b0;
                            else if (!free_any)
                                status_next = ST_FULL;
                        end
                        KIND_LEAVE, KIND_QUERY:
                            if (!found_now)
                                status_next = ST_NOCHG;
                        KIND_MOVE:
                        begin
                            if (!found_now || decide_state == S_DONE)
                                status_next = ST_NOCHG;
                            pass_next = 1'b0;
                        end
                        KIND_MODE:
                        begin
                            if (!found_now)
                                status_next = ST_NOCHG;
                            else if (self_now_data.watch == item_reg.watch_flag &&
                                     self_now_data.mark == item_reg.mark_flag)
                                status_next = ST_NOCHG;
                            if (found_now)
                            begin
                                // Store the new flags now; a rising watch also scans.
                                ram_we          = 1'b1;
                                ram_addr        = self_now;
                                ram_wdata       = self_now_data;
                                ram_wdata.watch = item_reg.watch_flag;
                                ram_wdata.mark  = item_reg.mark_flag;
                                self_data_next  = ram_wdata;
                            end
                        end
                        default:
                            status_next = ST_NOCHG;
                    endcase
                end
            end
            S_WRITE:
            begin
                // Enter: place the object. Move: store the new position.
                // Mode: flags were written already, only start the scan.
                idx_next = '0;
                mask_next = '0;
                if (item_reg.kind == KIND_ENTER)
                begin
                    self_next                = free_idx;
                    self_data_next.ident     = item_reg.object_id;
                    self_data_next.x         = item_reg.coord_x;
                    self_data_next.y         = item_reg.coord_y;
                    self_data_next.z         = item_reg.coord_z;
                    self_data_next.watch     = item_reg.watch_flag;
                    self_data_next.mark      = item_reg.mark_flag;
                    used_next[free_idx]      = 1'b1;
                    ram_we                   = 1'b1;
                    ram_addr                 = free_idx;
                    ram_wdata                = self_data_next;
                    pass_next                = 1'b1;
                end
                else if (item_reg.kind == KIND_MOVE)
                begin
                    before_next      = mask_reg;
                    self_data_next.x = item_reg.coord_x;
                    self_data_next.y = item_reg.coord_y;
                    self_data_next.z = item_reg.coord_z;
                    ram_we           = 1'b1;
                    ram_addr         = self_reg;
                    ram_wdata        = self_data_next;
                    pass_next        = 1'b1;
                    phase_next       = 1'b0;
                end
            end
            S_SCAN_RD:
            begin
                ram_addr = idx_reg;
            end
            S_SCAN:
            begin
                ids_we   = 1'b1;
                watch_bits_next[idx_reg] = ram_rdata.watch;
                if (idx_reg != self_reg && used_reg[idx_reg] && hit)
                    mask_next[idx_reg] = 1'b1;
                idx_next = last_idx ? '0 : idx_reg + AW'(1);
                sub_next = 1'b0;
                if (last_idx && item_reg.kind == KIND_MOVE && !pass_reg)
                    before_next = mask_next;
            end
            S_EMIT:
            begin
                if (!emit_any)
                begin
                    // Pass finished: free a leaving slot or start the move leave phase.
                    if (item_reg.kind == KIND_ENTER && !pass_reg)
                    begin
                        used_next[self_reg] = 1'b0;
                    end
                    else if (item_reg.kind == KIND_LEAVE)
                    begin
                        used_next[self_reg] = 1'b0;
                    end
                    else if (item_reg.kind == KIND_MOVE && pass_reg && !phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                end
                else if (out_free)
                begin
                    // Walk the pairs of the lowest pending member.
                    if (item_reg.kind == KIND_QUERY || item_reg.kind == KIND_MODE)
                    begin
                        out_next.event_kind = pair_kind;
                        out_next.watcher_id = self_data_reg.ident;
                        out_next.target_id  = ids_reg[emit_idx];
                        out_next.status     = ST_OK;
                        out_next.last       = 1'b0;
                        out_valid_next      = 1'b1;
                        member_done         = 1'b1;
                    end
                    else if (!sub_reg)
                    begin
                        if (self_data_reg.watch)
                        begin
                            out_next.event_kind = pair_kind;
                            out_next.watcher_id = self_data_reg.ident;
                            out_next.target_id  = ids_reg[emit_idx];
                            out_next.status     = ST_OK;
                            out_next.last       = 1'b0;
                            out_valid_next      = 1'b1;
                        end
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        if (other_watch)
                        begin
                            out_next.event_kind = pair_kind;
                            out_next.watcher_id = ids_reg[emit_idx];
                            out_next.target_id  = self_data_reg.ident;
                            out_next.status     = ST_OK;
                            out_next.last       = 1'b0;
                            out_valid_next      = 1'b1;
                        end
                        sub_next    = 1'b0;
                        member_done = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.event_kind = EV_DONE;
                    out_next.watcher_id = item_reg.object_id;
                    out_next.target_id  = '0;
                    out_next.status     = status_reg;
                    out_next.last       = 1'b1;
                    out_valid_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Clear the emitted member from whichever mask holds it.
        if (member_done)
        begin
            if (item_reg.kind == KIND_MOVE && phase_reg)
                before_next[emit_idx] = 1'b0;
            else
                mask_next[emit_idx] = 1'b0;
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            half_x_reg    <= HALF_RESET;
            half_y_reg    <= HALF_RESET;
            half_z_reg    <= HALF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HALF_X: half_x_reg <= cfg_data;
                    CFG_HALF_Y: half_y_reg <= cfg_data;
                    CFG_HALF_Z: half_z_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_item;
        before_reg     <= before_next;
        mask_reg       <= mask_next;
        idx_reg        <= idx_next;
        self_reg       <= self_next;
        found_reg      <= found_next;
        self_data_reg  <= self_data_next;
        pass_reg       <= pass_next;
        phase_reg      <= phase_next;
        sub_reg        <= sub_next;
        status_reg     <= status_next;
        watch_bits_reg <= watch_bits_next;
        out_reg        <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    // Input is taken only while idle.
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> state_reg == S_IDLE)
        else $error("item taken while busy");
    // A done result always closes an item.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.event_kind == EV_DONE |-> out_item.last)
        else $error("done without last");
    // After a done is sent the sequencer returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> state_reg == S_IDLE)
        else $error("done did not finish item");
    // Memory is written only while placing, moving or on mode change.
    a_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_WRITE || state_reg == S_FIND)
        else $error("unexpected slot write");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the area-of-interest tracker.
`timescale 1ns / 1ps

module testbench
    import tracker_pkg::*;
();

    localparam int SLOTS = 16;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    area_of_interest_tracker #(.MAX_OBJECTS(SLOTS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predicted object table and view sizes.
    logic                  tab_used [SLOTS] = '{default: 1'b0};
    logic [31:0]           tab_id [SLOTS];
    logic signed [31:0]    tab_x [SLOTS];
    logic signed [31:0]    tab_y [SLOTS];
    logic signed [31:0]    tab_z [SLOTS];
    logic                  tab_watch [SLOTS];
    logic                  tab_mark [SLOTS];
    logic [30:0]           half_x, half_y, half_z;

    in_item_t  pending_items [$];
    out_item_t expected_events [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  events_seen = 0;
    int  idle_cycles = 0;
    logic quiet;
    logic in_ready_seen;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Axis proximity with 64-bit arithmetic so no difference overflows.
    function automatic logic axis_close(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input longint h);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
        begin
            d = -d;
        end
        return d <= h;
    endfunction

    function automatic logic [SLOTS-1:0] visible_from(input int self, input longint hx,
                                                      input longint hy, input longint hz);
        logic [SLOTS-1:0] m;
        m = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i != self && tab_used[i] && axis_close(tab_x[i], tab_x[self], hx)
                && axis_close(tab_y[i], tab_y[self], hy)
                && axis_close(tab_z[i], tab_z[self], hz))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [SLOTS-1:0] config_view(input int self);
        return visible_from(self, longint'(half_x), longint'(half_y), longint'(half_z));
    endfunction

    task automatic push_event(input logic [1:0] k, input logic [31:0] w,
                              input logic [31:0] t, input logic [1:0] st, input logic l);
        out_item_t r;
        r.event_kind = k;
        r.watcher_id = w;
        r.target_id  = t;
        r.status     = st;
        r.last       = l;
        expected_events.push_back(r);
    endtask

    task automatic pair_notices(input logic [1:0] k, input int self,
                                input logic [SLOTS-1:0] m);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (m[i])
            begin
                if (tab_watch[self])
                begin
                    push_event(k, tab_id[self], tab_id[i], ST_OK, 1'b0);
                end
                if (tab_watch[i])
                begin
                    push_event(k, tab_id[i], tab_id[self], ST_OK, 1'b0);
                end
            end
        end
    endtask

    // Work out every event one accepted command causes.
    task automatic predict_events(input in_item_t it);
        int s;
        int f;
        logic [1:0] st;
        logic [SLOTS-1:0] old_m;
        logic [SLOTS-1:0] new_m;
        logic was_watch;
        s = -1;
        f = -1;
        st = ST_OK;
        if (it.kind > KIND_QUERY || (it.kind == KIND_ENTER && it.object_id == RESERVED_ID))
        begin
            push_event(EV_DONE, it.object_id, '0, ST_NOCHG, 1'b1);
            return;
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (tab_used[i] && tab_id[i] == it.object_id)
            begin
                s = i;
            end
        end
        if (it.kind == KIND_ENTER)
        begin
            if (s >= 0)
            begin
                pair_notices(EV_LEAVE, s, config_view(s));
                tab_used[s] = 1'b0;
            end
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!tab_used[i])
                begin
                    f = i;
                end
            end
            if (f < 0)
            begin
                push_event(EV_DONE, it.object_id, '0, ST_FULL, 1'b1);
                return;
            end
            tab_used[f]  = 1'b1;
            tab_id[f]    = it.object_id;
            tab_x[f]     = it.coord_x;
            tab_y[f]     = it.coord_y;
            tab_z[f]     = it.coord_z;
            tab_watch[f] = it.watch_flag;
            tab_mark[f]  = it.mark_flag;
            pair_notices(EV_ENTER, f, config_view(f));
        end
        else if (s < 0)
        begin
            st = ST_NOCHG;
        end
        else if (it.kind == KIND_LEAVE)
        begin
            pair_notices(EV_LEAVE, s, config_view(s));
            tab_used[s] = 1'b0;
        end
        else if (it.kind == KIND_MOVE)
        begin
            if (tab_x[s] == it.coord_x && tab_y[s] == it.coord_y && tab_z[s] == it.coord_z)
            begin
                st = ST_NOCHG;
            end
            else
            begin
                old_m = config_view(s);
                tab_x[s] = it.coord_x;
                tab_y[s] = it.coord_y;
                tab_z[s] = it.coord_z;
                new_m = config_view(s);
                pair_notices(EV_ENTER, s, new_m & ~old_m);
                pair_notices(EV_LEAVE, s, old_m & ~new_m);
            end
        end
        else if (it.kind == KIND_MODE)
        begin
            was_watch = tab_watch[s];
            if (tab_watch[s] == it.watch_flag && tab_mark[s] == it.mark_flag)
            begin
                st = ST_NOCHG;
            end
            tab_watch[s] = it.watch_flag;
            tab_mark[s]  = it.mark_flag;
            if (!was_watch && it.watch_flag)
            begin
                new_m = config_view(s);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (new_m[i])
                    begin
                        push_event(EV_ENTER, tab_id[s], tab_id[i], ST_OK, 1'b0);
                    end
                end
            end
        end
        else
        begin
            if (it.own_range)
            begin
                new_m = visible_from(s, longint'(it.coord_x), longint'(it.coord_y),
                                     longint'(it.coord_z));
            end
            else
            begin
                new_m = config_view(s);
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (new_m[i])
                begin
                    push_event(EV_VIEW, tab_id[s], tab_id[i], ST_OK, 1'b0);
                end
            end
        end
        push_event(EV_DONE, it.object_id, '0, st, 1'b1);
    endtask

    // Random idling: about a quarter of cycles, none while quiet is set.
    function automatic logic take_break();
        return !quiet && ($urandom_range(99) < 24);
    endfunction

    // Predictor: works out the results of each item as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_events(in_item);
            items_sent <= items_sent + 1;
        end
    end

    // Remember whether the item on the bus was taken at the last rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready_seen <= 1'b0;
        end
        else
        begin
            in_ready_seen <= in_valid && in_ready;
        end
    end

    // Driver: presents queued items and the output ready at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_item   <= '0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (pending_items.size() > 0 && !take_break())
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= !take_break();
        end
    end

    // Monitor: compares each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (out_valid && out_ready)
            begin
                events_seen <= events_seen + 1;
                if (expected_events.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("unexpected result %p", out_item);
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want !== out_item)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("result differs: expected %p, got %p", want, out_item);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("area_of_interest_tracker: mismatch");
            $finish;
        end
    end

    function automatic logic signed [31:0] near_coord();
        return $signed(32'($urandom_range(40)) << 15) - 32'sd655360;
    endfunction

    function automatic logic [31:0] pick_id();
        return 32'($urandom_range(19)) + 32'd100;
    endfunction

    function automatic in_item_t make_item(input logic [2:0] k, input logic [31:0] id,
                                           input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z,
                                           input logic w, input logic m, input logic o);
        in_item_t it;
        it.kind = k;
        it.object_id = id;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.watch_flag = w;
        it.mark_flag = m;
        it.own_range = o;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_events.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_half(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_HALF_X: half_x = val;
            CFG_HALF_Y: half_y = val;
            default:    half_z = val;
        endcase
    endtask

    task automatic random_phase(input int count);
        logic [2:0] k;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2: k = KIND_ENTER;
                3:       k = KIND_LEAVE;
                4, 5:    k = KIND_MOVE;
                6:       k = KIND_MODE;
                7, 8:    k = KIND_QUERY;
                default: k = 3'($urandom_range(7));
            endcase
            if ($urandom_range(19) == 0)
            begin
                pending_items.push_back(make_item(k, $urandom(), $urandom(), $urandom(),
                                                  $urandom(), 1'($urandom_range(1)),
                                                  1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
            end
            else
            begin
                pending_items.push_back(make_item(k, pick_id(), near_coord(), near_coord(),
                                                  near_coord(), 1'($urandom_range(1)),
                                                  1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HALF_X;
        cfg_data = '0;
        quiet = 1'b0;
        half_x = HALF_RESET;
        half_y = HALF_RESET;
        half_z = HALF_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: absent ids, reserved id, unknown kind, extremes, own range.
        pending_items.push_back(make_item(KIND_LEAVE, 32'd5, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_MOVE, 32'd5, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_ENTER, RESERVED_ID, '0, '0, '0,
                                          1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_item(3'd7, 32'd5, '0, '0, '0, 1'b1, 1'b1, 1'b1));
        pending_items.push_back(make_item(KIND_ENTER, 32'd0, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_ENTER, 32'hFFFF_FFFE, 32'sd655360, '0,
                                          -32'sd655360, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_item(KIND_ENTER, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h8000_0000, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_item(KIND_ENTER, 32'd8, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_MOVE, 32'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_MOVE, 32'd0, 32'sd655361, '0, '0,
                                          1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_MODE, 32'd7, '0, '0, '0, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_item(KIND_MODE, 32'd7, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_QUERY, 32'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(KIND_QUERY, 32'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_item(KIND_QUERY, 32'd0, -32'sd1, 32'sd1000000,
                                          32'sd1000000, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_item(KIND_ENTER, 32'd0, 32'sd100, '0, '0,
                                          1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_item(KIND_LEAVE, 32'hFFFF_FFFE, '0, '0, '0,
                                          1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 17; i++)
        begin
            pending_items.push_back(make_item(KIND_ENTER, 32'(200 + i), '0, '0, '0,
                                              i[0], i[1], 1'b0));
        end
        drain();

        // Random phases over several view sizes, extremes among them.
        write_half(CFG_HALF_X, '0);
        write_half(CFG_HALF_Y, 31'h7FFF_FFFF);
        write_half(CFG_HALF_Z, 31'h7FFF_FFFF);
        for (int i = 0; i < SLOTS; i++)
        begin
            pending_items.push_back(make_item(KIND_LEAVE, 32'(200 + i), '0, '0, '0,
                                              1'b0, 1'b0, 1'b0));
        end
        random_phase(60);
        drain();
        write_half(CFG_HALF_X, 31'd327680);
        write_half(CFG_HALF_Y, 31'd655360);
        write_half(CFG_HALF_Z, 31'd983040);
        quiet = 1'b1;
        random_phase(50);
        drain();
        quiet = 1'b0;
        write_half(CFG_HALF_X, 31'h7FFF_FFFF);
        write_half(CFG_HALF_Y, '0);
        write_half(CFG_HALF_Z, 31'd1);
        random_phase(40);
        drain();
        write_half(CFG_HALF_X, HALF_RESET);
        write_half(CFG_HALF_Y, HALF_RESET);
        write_half(CFG_HALF_Z, HALF_RESET);
        random_phase(70);
        drain();

        $display("Sent %0d commands and checked %0d results across four view settings.",
                 items_sent, events_seen);
        if (mismatches == 0)
        begin
            $display("area_of_interest_tracker: match");
        end
        else
        begin
            $display("area_of_interest_tracker: mismatch");
        end
        $finish;
    end

endmodule
